>>> sv/htdl_pkg.sv
`timescale 1ns / 1ps

package htdl_pkg;

    localparam int NODE_W = 9;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] TAG_LEAF  = 8'h4C;
    localparam logic [BYTE_W-1:0] TAG_INNER = 8'h49;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_EMPTY     = 2'd3
    } err_t;

    // one operation on the node index stack
    typedef struct packed {
        logic              push;
        logic              merge;
        logic              clear;
        logic [NODE_W-1:0] node;
    } stk_cmd_t;

    typedef struct packed {
        logic              node_valid;
        logic [NODE_W-1:0] node_number;
        logic              leaf_flag;
        logic [BYTE_W-1:0] leaf_symbol;
        logic [NODE_W-1:0] left_child;
        logic [NODE_W-1:0] right_child;
        logic              dump_done;
        logic [NODE_W-1:0] root_node;
        err_t              error_code;
    } res_t;

endpackage

>>> sv/htdl_stack.sv
`timescale 1ns / 1ps

module htdl_stack #(
    parameter int MAX_LEAVES = 256,
    localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1,
    localparam int DW = $clog2(MAX_LEAVES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  htdl_pkg::stk_cmd_t         cmd,
    output logic [htdl_pkg::NODE_W-1:0] tos,
    output logic [htdl_pkg::NODE_W-1:0] nos,
    output logic [DW-1:0]              depth
);
    import htdl_pkg::*;

    // top two entries live in registers, the rest below them in memory
    logic [NODE_W-1:0] mem [MAX_LEAVES];

    logic [DW-1:0]     depth_reg, depth_op, depth_next;
    logic [NODE_W-1:0] tos_reg, tos_next, nos_reg, nos_next;
    logic [NODE_W-1:0] rd_data_reg, byp_data_reg, mem_top;
    logic              byp_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;

    always_comb
    begin
        // memory top: freshly written entry or the prefetched read
        mem_top  = byp_reg ? byp_data_reg : rd_data_reg;
        depth_op = depth_reg;
        tos_next = tos_reg;
        nos_next = nos_reg;
        if (cmd.push)
        begin
            depth_op = depth_reg + DW'(1);
            tos_next = cmd.node;
            nos_next = tos_reg;
        end
        else if (cmd.merge)
        begin
            depth_op = depth_reg - DW'(1);
            tos_next = cmd.node;
            nos_next = mem_top;
        end
        depth_next = cmd.clear ? '0 : depth_op;
        wr_en      = cmd.push && (depth_reg >= DW'(2));
        wr_addr    = AW'(depth_reg - DW'(2));
        // prefetch the entry just below the register pair
        rd_addr    = (depth_op >= DW'(3)) ? AW'(depth_op - DW'(3)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= nos_reg;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= nos_reg;
        tos_reg      <= tos_next;
        nos_reg      <= nos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            byp_reg   <= wr_en;
        end
    end

    assign tos   = tos_reg;
    assign nos   = nos_reg;
    assign depth = depth_reg;

endmodule

>>> sv/htdl_skid.sv
`timescale 1ns / 1ps

module htdl_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  htdl_pkg::res_t  res,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output htdl_pkg::res_t  data
);
    import htdl_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next, skid_reg, skid_next;
    logic out_fire;

    always_comb
    begin
        out_fire        = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // input is held off; drain the skid entry first
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign data      = out_reg;

endmodule

>>> sv/huffman_tree_dump_loader.sv
`timescale 1ns / 1ps

// Post-order Huffman tree dump loader.
// Input channel (in_valid / in_stall): one dump byte per item, last_byte set
// on the final byte. 'L' then a symbol byte makes a leaf; 'I' joins the two
// top stack entries into an interior node; any other tag skips the next byte.
// Output channel (out_valid / out_stall): one result item for each byte that
// creates a node or is the last byte; other bytes produce no result.
// Throughput: one item per cycle while in_stall is low. The node stack keeps
// its top two entries in registers and prefetches the third from a memory
// with separate read and write ports, so every push or merge completes in the
// cycle the byte is taken. Each result is registered before it is offered.
// Stall: the output register is backed by a one-entry skid buffer; in_stall
// rises only once that skid entry is occupied, and results are never dropped.
// Reset: stack, node counter, byte phase and error are cleared; no memory
// clearing pass is needed. The same clear happens after every last byte.
// Errors are sticky per dump: 1 underflow on 'I', 2 stack overflow,
// 3 empty stack at the end.
module huffman_tree_dump_loader #(
    parameter int MAX_LEAVES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [htdl_pkg::BYTE_W-1:0] dump_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        node_valid,
    output logic [htdl_pkg::NODE_W-1:0] node_number,
    output logic                        leaf_flag,
    output logic [htdl_pkg::BYTE_W-1:0] leaf_symbol,
    output logic [htdl_pkg::NODE_W-1:0] left_child,
    output logic [htdl_pkg::NODE_W-1:0] right_child,
    output logic                        dump_done,
    output logic [htdl_pkg::NODE_W-1:0] root_node,
    output logic [1:0]                  error_code
);
    import htdl_pkg::*;

    localparam int DW = $clog2(MAX_LEAVES + 1);

    typedef enum logic [2:0] {
        PH_TAG  = 3'b001,
        PH_SYM  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    err_t              err_reg, err_next, err_op, err_fin;
    logic [NODE_W-1:0] next_node_reg, next_node_next;

    logic              accept;
    logic              tag_leaf, tag_inner;
    logic              do_leaf, do_merge, made, ovf, unf;
    logic [DW-1:0]     depth_after;
    logic [NODE_W-1:0] tos_after;

    stk_cmd_t          stk_cmd;
    logic [NODE_W-1:0] stk_tos, stk_nos;
    logic [DW-1:0]     stk_depth;

    res_t              res, out_data;
    logic              res_valid;
    logic              skid_full;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        tag_leaf  = (dump_byte == TAG_LEAF);
        tag_inner = (dump_byte == TAG_INNER);

        // node work only while no error is pending in this dump
        do_leaf  = accept && (phase_reg == PH_SYM) && (err_reg == ERR_NONE)
                   && (stk_depth < DW'(MAX_LEAVES));
        ovf      = accept && (phase_reg == PH_SYM) && (err_reg == ERR_NONE)
                   && (stk_depth >= DW'(MAX_LEAVES));
        do_merge = accept && (phase_reg == PH_TAG) && tag_inner
                   && (err_reg == ERR_NONE) && (stk_depth >= DW'(2));
        unf      = accept && (phase_reg == PH_TAG) && tag_inner
                   && (err_reg == ERR_NONE) && (stk_depth < DW'(2));
        made     = do_leaf || do_merge;

        depth_after = stk_depth;
        if (do_leaf)
        begin
            depth_after = stk_depth + DW'(1);
        end
        else if (do_merge)
        begin
            depth_after = stk_depth - DW'(1);
        end
        tos_after = made ? next_node_reg : stk_tos;

        priority if (err_reg != ERR_NONE)
        begin
            err_op = err_reg;
        end
        else if (ovf)
        begin
            err_op = ERR_OVERFLOW;
        end
        else if (unf)
        begin
            err_op = ERR_UNDERFLOW;
        end
        else
        begin
            err_op = ERR_NONE;
        end

        // an empty stack at the end counts only if nothing failed earlier
        err_fin = err_op;
        if (last_byte && (err_op == ERR_NONE) && (depth_after == '0))
        begin
            err_fin = ERR_EMPTY;
        end

        // advance the byte phase; the last byte always drops what is pending
        unique case (phase_reg)
            PH_SYM:  phase_next = PH_TAG;
            PH_SKIP: phase_next = PH_TAG;
            PH_TAG:
            begin
                if (tag_leaf)
                begin
                    phase_next = PH_SYM;
                end
                else if (tag_inner)
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            default: phase_next = PH_TAG;
        endcase

        if (!accept)
        begin
            phase_next     = phase_reg;
            err_next       = err_reg;
            next_node_next = next_node_reg;
        end
        else if (last_byte)
        begin
            phase_next     = PH_TAG;
            err_next       = ERR_NONE;
            next_node_next = '0;
        end
        else
        begin
            err_next       = err_fin;
            next_node_next = made ? next_node_reg + NODE_W'(1) : next_node_reg;
        end

        stk_cmd.push  = do_leaf;
        stk_cmd.merge = do_merge;
        stk_cmd.clear = accept && last_byte;
        stk_cmd.node  = next_node_reg;

        res_valid       = accept && (made || last_byte);
        res.node_valid  = made;
        res.node_number = made ? next_node_reg : '0;
        res.leaf_flag   = do_leaf;
        res.leaf_symbol = do_leaf ? dump_byte : '0;
        res.left_child  = do_merge ? stk_nos : '0;
        res.right_child = do_merge ? stk_tos : '0;
        res.dump_done   = last_byte;
        res.root_node   = (last_byte && (depth_after != '0)) ? tos_after : '0;
        res.error_code  = err_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            err_reg       <= ERR_NONE;
            next_node_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            next_node_reg <= next_node_next;
        end
    end

    htdl_stack #(
        .MAX_LEAVES(MAX_LEAVES)
    ) u_stack (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (stk_cmd),
        .tos  (stk_tos),
        .nos  (stk_nos),
        .depth(stk_depth)
    );

    htdl_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_valid(res_valid),
        .res      (res),
        .full     (skid_full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data     (out_data)
    );

    // hold off new bytes only while the skid entry is occupied
    assign in_stall    = skid_full;

    assign node_valid  = out_data.node_valid;
    assign node_number = out_data.node_number;
    assign leaf_flag   = out_data.leaf_flag;
    assign leaf_symbol = out_data.leaf_symbol;
    assign left_child  = out_data.left_child;
    assign right_child = out_data.right_child;
    assign dump_done   = out_data.dump_done;
    assign root_node   = out_data.root_node;
    assign error_code  = out_data.error_code;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_depth <= DW'(MAX_LEAVES))
        else $error("stack depth beyond capacity");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (stk_depth == '0 && next_node_reg == '0
                                   && err_reg == ERR_NONE))
        else $error("state not cleared after last byte");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !(accept && last_byte)) |=> (err_reg == $past(err_reg)))
        else $error("sticky error changed within a dump");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");
`endif

endmodule

>>> dv/huffman_tree_dump_loader_test.sv
`timescale 1ns / 1ps

module huffman_tree_dump_loader_test;

    import htdl_pkg::*;

    localparam int MAX_LEAVES   = 256;
    localparam int IDLE_PCT     = 22;      // chance in a hundred that a side idles
    localparam int QUIET_FROM   = 1000;    // cycle window with no idling on either side
    localparam int QUIET_TO     = 1600;
    localparam int STIM_ITEMS   = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;

    // One row of stimulus. When hand_checked is set, the result fields hold the
    // expected record written out by hand; otherwise the predictor decides.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              hand_checked;
        logic              nv;
        logic [NODE_W-1:0] num;
        logic              leaf;
        logic [BYTE_W-1:0] sym;
        logic [NODE_W-1:0] lc;
        logic [NODE_W-1:0] rc;
        logic              done;
        logic [NODE_W-1:0] root;
        err_t              err;
    } dump_item_t;

    typedef enum logic [1:0] {
        AWAIT_TAG,
        AWAIT_SYMBOL,
        SKIP_NEXT
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] dump_byte = '0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              node_valid;
    logic [NODE_W-1:0] node_number;
    logic              leaf_flag;
    logic [BYTE_W-1:0] leaf_symbol;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic              dump_done;
    logic [NODE_W-1:0] root_node;
    logic [1:0]        error_code;

    huffman_tree_dump_loader #(
        .MAX_LEAVES(MAX_LEAVES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dump_byte   (dump_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_valid  (node_valid),
        .node_number (node_number),
        .leaf_flag   (leaf_flag),
        .leaf_symbol (leaf_symbol),
        .left_child  (left_child),
        .right_child (right_child),
        .dump_done   (dump_done),
        .root_node   (root_node),
        .error_code  (error_code)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Loader model: node index stack, node counter, byte phase and the
    // sticky error of the dump being parsed.
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] node_stack [0:MAX_LEAVES-1];
    int unsigned       stack_fill;
    logic [NODE_W-1:0] node_count;
    parse_phase_t      parse_phase;
    err_t              dump_err;

    dump_item_t stim_q [$];
    res_t       pending_records [$];
    dump_item_t cur_item;
    dump_item_t directed_rows [25];
    int         fault_count = 0;
    int         cycle_count = 0;

    function automatic void rearm_loader();
        stack_fill  = 0;
        node_count  = '0;
        parse_phase = AWAIT_TAG;
        dump_err    = ERR_NONE;
    endfunction

    // Keep only the first error of a dump.
    function automatic void raise_err(err_t code);
        if (dump_err == ERR_NONE)
            dump_err = code;
    endfunction

    function automatic void push_new_node();
        node_stack[stack_fill] = node_count;
        stack_fill++;
        node_count++;
    endfunction

    // Advance the loader model by one byte; return 1 when a record comes out.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                                       output res_t rec);
        bit made;
        made = 1'b0;
        rec  = '0;
        case (parse_phase)
            AWAIT_SYMBOL:
            begin
                parse_phase = AWAIT_TAG;
                if (dump_err == ERR_NONE)
                begin
                    if (stack_fill >= MAX_LEAVES)
                        raise_err(ERR_OVERFLOW);
                    else
                    begin
                        rec.node_number = node_count;
                        rec.leaf_flag   = 1'b1;
                        rec.leaf_symbol = b;
                        push_new_node();
                        made = 1'b1;
                    end
                end
            end
            SKIP_NEXT:
                parse_phase = AWAIT_TAG;
            default:
            begin
                if (b == TAG_LEAF)
                    parse_phase = AWAIT_SYMBOL;
                else if (b == TAG_INNER)
                begin
                    if (dump_err == ERR_NONE)
                    begin
                        if (stack_fill < 2)
                            raise_err(ERR_UNDERFLOW);
                        else
                        begin
                            rec.right_child = node_stack[stack_fill - 1];
                            rec.left_child  = node_stack[stack_fill - 2];
                            stack_fill      = stack_fill - 2;
                            rec.node_number = node_count;
                            push_new_node();
                            made = 1'b1;
                        end
                    end
                end
                else
                    parse_phase = SKIP_NEXT;
            end
        endcase
        if (last)
        begin
            if (stack_fill == 0)
                raise_err(ERR_EMPTY);
            else
                rec.root_node = node_stack[stack_fill - 1];
        end
        rec.node_valid = made;
        rec.dump_done  = last;
        rec.error_code = dump_err;
        if (last)
            rearm_loader();
        return made || last;
    endfunction

    // ------------------------------------------------------------------
    // Dump builders
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [BYTE_W-1:0] b);
        dump_item_t it;
        it      = '0;
        it.data = b;
        stim_q.push_back(it);
    endfunction

    // Mark the final byte of the dump just queued.
    function automatic void close_dump();
        dump_item_t it;
        it      = stim_q.pop_back();
        it.last = 1'b1;
        stim_q.push_back(it);
    endfunction

    // Mostly random symbols, now and then one that looks like a tag.
    function automatic logic [BYTE_W-1:0] rand_symbol();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? TAG_LEAF : TAG_INNER;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_leaf(logic [BYTE_W-1:0] sym);
        queue_byte(TAG_LEAF);
        queue_byte(sym);
    endfunction

    // Well-formed post-order dump of a random tree with the given leaf count.
    function automatic void queue_tree_dump(int unsigned leaves);
        int unsigned to_place;
        int unsigned open_nodes;
        to_place   = leaves;
        open_nodes = 0;
        while (to_place != 0 || open_nodes > 1)
        begin
            if (to_place != 0 && (open_nodes < 2 || $urandom_range(0, 1) == 1))
            begin
                queue_leaf(rand_symbol());
                to_place--;
                open_nodes++;
            end
            else
            begin
                queue_byte(TAG_INNER);
                open_nodes--;
            end
        end
    endfunction

    // Noise: leaves, joins, unknown tags and loose bytes in any order.
    function automatic void queue_broken_dump(int unsigned tokens);
        int unsigned       pick;
        logic [BYTE_W-1:0] tag;
        repeat (tokens)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                queue_leaf(rand_symbol());
            else if (pick < 60)
                queue_byte(TAG_INNER);
            else if (pick < 80)
            begin
                do
                    tag = 8'($urandom_range(0, 255));
                while (tag == TAG_LEAF || tag == TAG_INNER);
                queue_byte(tag);
                queue_byte(8'($urandom_range(0, 255)));
            end
            else
                queue_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string fmt_record(res_t r);
        return $sformatf("nv=%0b num=%0d leaf=%0b sym=%02h lc=%0d rc=%0d done=%0b root=%0d err=%0d",
                         r.node_valid, r.node_number, r.leaf_flag, r.leaf_symbol,
                         r.left_child, r.right_child, r.dump_done, r.root_node, r.error_code);
    endfunction

    function automatic void note_fault(string what, res_t want, res_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s", what);
            $display("  expected %s", fmt_record(want));
            $display("  actual   %s", fmt_record(got));
        end
    endfunction

    // ------------------------------------------------------------------
    // Both channels run off one clocked block: take the accepted byte into
    // the model first, then check the record leaving the block, so a record
    // on the same edge as its byte still finds its expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : channels
        res_t predicted;
        res_t got;
        res_t want;
        bit   made;
        bit   quiet;

        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;

            // Feed the accepted byte to the model. Hand-written rows push their
            // own record; the model still advances so its state stays in step.
            if (in_valid && !in_stall)
            begin
                made = decode_byte(cur_item.data, cur_item.last, predicted);
                if (cur_item.hand_checked)
                    pending_records.push_back({cur_item.nv, cur_item.num, cur_item.leaf,
                                               cur_item.sym, cur_item.lc, cur_item.rc,
                                               cur_item.done, cur_item.root, cur_item.err});
                else if (made)
                    pending_records.push_back(predicted);
            end

            // Hold a stalled item; otherwise offer the next one or idle.
            if (!in_valid || !in_stall)
            begin
                if (stim_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_item = stim_q.pop_front();
                    in_valid  <= 1'b1;
                    dump_byte <= cur_item.data;
                    last_byte <= cur_item.last;
                end
                else
                    in_valid <= 1'b0;
            end

            // Compare each taken record, field by field, with the oldest expectation.
            if (out_valid && !out_stall)
            begin
                got = {node_valid, node_number, leaf_flag, leaf_symbol, left_child,
                       right_child, dump_done, root_node, error_code};
                if (pending_records.size() == 0)
                    note_fault("record with nothing expected", '0, got);
                else
                begin
                    want = pending_records.pop_front();
                    if (got.node_valid  !== want.node_valid  ||
                        got.node_number !== want.node_number ||
                        got.leaf_flag   !== want.leaf_flag   ||
                        got.leaf_symbol !== want.leaf_symbol ||
                        got.left_child  !== want.left_child  ||
                        got.right_child !== want.right_child ||
                        got.dump_done   !== want.dump_done   ||
                        got.root_node   !== want.root_node   ||
                        got.error_code  !== want.error_code)
                        note_fault("record mismatch", want, got);
                end
            end

            out_stall <= !quiet && $urandom_range(0, 99) < IDLE_PCT;
        end
    end

    // Give up on a hung run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("huffman_tree_dump_loader_test NOT OK");
        $finish;
    end

    initial
    begin
        int dump_idx;

        rearm_loader();

        // Directed part. Columns: byte, last, hand-checked, then the expected
        // record: nv, num, leaf, sym, lc, rc, done, root, err.
        directed_rows = '{
            // join on an empty stack right after reset, ending the dump at once
            '{TAG_INNER, 1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 0, ERR_UNDERFLOW},
            // lowest and highest symbols, then a join of the two
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{8'h00,     0, 1,  1, 0, 1, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{8'hFF,     0, 1,  1, 1, 1, 8'hFF, 0, 0,  0, 0, ERR_NONE},
            '{TAG_INNER, 0, 1,  1, 2, 0, 8'h00, 0, 1,  0, 0, ERR_NONE},
            // join with a single entry left: underflow, root stays on top
            '{TAG_INNER, 1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 2, ERR_UNDERFLOW},
            // unknown tag as the only byte: empty stack at the end
            '{8'h00,     1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 0, ERR_EMPTY},
            // symbols equal to the tag values are plain symbols
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_LEAF,  0, 1,  1, 0, 1, 8'h4C, 0, 0,  0, 0, ERR_NONE},
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_INNER, 0, 1,  1, 1, 1, 8'h49, 0, 0,  0, 0, ERR_NONE},
            // unknown tag swallows the join behind it
            '{8'h01,     0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_INNER, 0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            // last byte on a leaf tag: drop the pending leaf, two entries left
            '{TAG_LEAF,  1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 1, ERR_NONE},
            // leaf and end of dump in the same record
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{8'hAA,     1, 1,  1, 0, 1, 8'hAA, 0, 0,  1, 0, ERR_NONE},
            // last byte while a skip is pending
            '{8'hFF,     0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_LEAF,  1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 0, ERR_EMPTY},
            // small clean tree, join and end together
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{8'h7F,     0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_LEAF,  0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{8'h80,     0, 0,  0, 0, 0, 8'h00, 0, 0,  0, 0, ERR_NONE},
            '{TAG_INNER, 1, 1,  1, 2, 0, 8'h00, 0, 1,  1, 2, ERR_NONE},
            // leaf tag alone as the whole dump
            '{TAG_LEAF,  1, 1,  0, 0, 0, 8'h00, 0, 0,  1, 0, ERR_EMPTY}
        };
        foreach (directed_rows[i])
            stim_q.push_back(directed_rows[i]);

        // Random part: mostly well-formed trees, some noise, plus two long dumps.
        dump_idx = 0;
        while (stim_q.size() < STIM_ITEMS)
        begin
            if (dump_idx == 3)
            begin
                // Chain of joins, then fill the stack to the brim and fold it back:
                // reaches node 511 and wraps the 9-bit node counter.
                queue_leaf(rand_symbol());
                repeat (2)
                begin
                    queue_leaf(rand_symbol());
                    queue_byte(TAG_INNER);
                end
                repeat (MAX_LEAVES - 1)
                    queue_leaf(rand_symbol());
                repeat (MAX_LEAVES - 1)
                    queue_byte(TAG_INNER);
            end
            else if (dump_idx == 12)
            begin
                // One leaf more than the stack holds, then joins that must be ignored.
                repeat (MAX_LEAVES + 1)
                    queue_leaf(rand_symbol());
                repeat (3)
                    queue_byte(TAG_INNER);
            end
            else if ($urandom_range(0, 99) < 20)
                queue_broken_dump($urandom_range(1, 10));
            else if ($urandom_range(0, 9) == 0)
                queue_tree_dump($urandom_range(13, 40));
            else
                queue_tree_dump($urandom_range(1, 12));
            close_dump();
            dump_idx++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every record to come out, then drain.
        do
            @(negedge clk);
        while (stim_q.size() != 0 || in_valid || pending_records.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0 && pending_records.size() == 0)
            $display("huffman_tree_dump_loader_test OK");
        else
            $display("huffman_tree_dump_loader_test NOT OK");
        $finish;
    end

endmodule

>>> huffman_tree_dump_loader.f
sv/htdl_pkg.sv
sv/htdl_stack.sv
sv/htdl_skid.sv
sv/huffman_tree_dump_loader.sv
dv/huffman_tree_dump_loader_test.sv
